// File: hw/rtl/pswa_pkg.sv
// ----------------------------------------------------------------------------
// pswa_pkg
// Shared widths, codes and types for the pressure sample window averager.
// ----------------------------------------------------------------------------
package pswa_pkg;

  // Field and state widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MEAN_W   = 12;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned CNT_W    = 16;

  // Highest number of samples taken into one window
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'hFFFF;

  // Restoring divide: one quotient bit per step over the whole sum
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

  // Operation codes carried on the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: hw/rtl/pswa_div.sv
// ----------------------------------------------------------------------------
// pswa_div
// Bit-serial restoring divider: sum by sample count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pswa_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pswa_pkg::SUM_W-1:0]      dividend,
  input  logic [pswa_pkg::CNT_W-1:0]      divisor,
  output pswa_pkg::div_sts_t              sts,
  output logic [pswa_pkg::MEAN_W-1:0]     quotient
);

  logic [pswa_pkg::SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [pswa_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [pswa_pkg::CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [pswa_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [pswa_pkg::CNT_W:0]    rem_sh;
  logic [pswa_pkg::CNT_W:0]    diff;
  logic                        ge;

  // Shift the next dividend bit into the partial remainder and trial-subtract
  assign rem_sh = {rem_r, dvd_r[pswa_pkg::SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // Load operands and arm the step counter
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = pswa_pkg::STEP_W'(pswa_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // One restoring step; quotient bits collect in the dividend register
      rem_nxt = ge ? diff[pswa_pkg::CNT_W-1:0] : rem_sh[pswa_pkg::CNT_W-1:0];
      dvd_nxt = {dvd_r[pswa_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r - pswa_pkg::STEP_W'(1);
      if (cnt_r == pswa_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  // The mean of in-range samples fits the low bits of the quotient
  assign quotient = dvd_r[pswa_pkg::MEAN_W-1:0];

endmodule

// File: hw/rtl/pressure_sample_window_average_top.sv
// ----------------------------------------------------------------------------
// pressure_sample_window_average_top
// Accumulate-and-dump averager for 12-bit pressure converter samples.
// ----------------------------------------------------------------------------
// A sample beat (tuser 0) adds to the window sum and count, or is dropped and
// flagged once the count is full. An update beat (tuser 1) gives one result
// beat with the truncated mean and clears the window; it holds the input off
// while the bit-serial divider, which produces one quotient bit per cycle over
// the 28-bit sum, runs and until the result is in the output register. An
// update on an empty window repeats the previous mean and flags it. A finished
// result waits in the output register while sample beats keep flowing in.
module pressure_sample_window_average_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample, [15:12] zero
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] average, [27:12] window_count, [31:28] zero
  output logic [1:0]  out_tuser   // [0] window_empty, [1] samples_dropped
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [pswa_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [pswa_pkg::CNT_W-1:0]      tally_r, tally_nxt;
  logic [pswa_pkg::MEAN_W-1:0]     last_mean_r, last_mean_nxt;
  logic                            ovf_r, ovf_nxt;

  // Pending result while the divide runs
  logic [pswa_pkg::MEAN_W-1:0]     res_avg_r, res_avg_nxt;
  logic [pswa_pkg::CNT_W-1:0]      res_cnt_r, res_cnt_nxt;
  logic                            res_empty_r, res_empty_nxt;
  logic                            res_drop_r, res_drop_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [pswa_pkg::MEAN_W-1:0]     out_avg_r, out_avg_nxt;
  logic [pswa_pkg::CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic                            out_empty_r, out_empty_nxt;
  logic                            out_drop_r, out_drop_nxt;

  logic                            in_acc;
  logic                            div_start;
  pswa_pkg::div_sts_t              div_sts;
  logic [pswa_pkg::MEAN_W-1:0]     div_q;
  logic [pswa_pkg::SAMPLE_W-1:0]   smp;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign smp       = in_tdata[pswa_pkg::SAMPLE_W-1:0];

  pswa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (tally_r),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Sequencer: accumulate, start the divide, hand the result to the output
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    tally_nxt     = tally_r;
    last_mean_nxt = last_mean_r;
    ovf_nxt       = ovf_r;
    res_avg_nxt   = res_avg_r;
    res_cnt_nxt   = res_cnt_r;
    res_empty_nxt = res_empty_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;
    out_empty_nxt = out_empty_r;
    out_drop_nxt  = out_drop_r;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == pswa_pkg::OP_SAMPLE) begin
            // Add the sample, or drop it once the window is full
            if (tally_r < pswa_pkg::MAX_SAMPLES) begin
              sum_nxt   = sum_r + pswa_pkg::SUM_W'(smp);
              tally_nxt = tally_r + pswa_pkg::CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            // Capture the window figures and restart the window
            res_cnt_nxt  = tally_r;
            res_drop_nxt = ovf_r;
            sum_nxt      = '0;
            tally_nxt    = '0;
            ovf_nxt      = 1'b0;
            if (tally_r == '0) begin
              res_avg_nxt   = last_mean_r;
              res_empty_nxt = 1'b1;
              state_nxt     = ST_EMIT;
            end else begin
              res_empty_nxt = 1'b0;
              div_start     = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        // Wait for the quotient
        if (div_sts.done) begin
          res_avg_nxt   = div_q;
          last_mean_nxt = div_q;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Load the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_avg_r;
          out_cnt_nxt   = res_cnt_r;
          out_empty_nxt = res_empty_r;
          out_drop_nxt  = res_drop_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      tally_r     <= '0;
      last_mean_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      tally_r     <= tally_nxt;
      last_mean_r <= last_mean_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_avg_r   <= res_avg_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_empty_r <= res_empty_nxt;
    res_drop_r  <= res_drop_nxt;
    out_avg_r   <= out_avg_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cnt_r, out_avg_r};
  assign out_tuser  = {out_drop_r, out_empty_r};

  // An update beat restarts the window
  a_update_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser[0] == pswa_pkg::OP_UPDATE) |=> (tally_r == '0) && (sum_r == '0))
    else $error("window not cleared after update");

  // The divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");

  // An empty-window result carries a zero count
  a_empty_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> (out_cnt_r == '0))
    else $error("empty window result with non-zero count");

endmodule

// File: bench/window_average_checker.sv
// ----------------------------------------------------------------------------
// window_average_checker
// Watches both streams of the pressure window averager and checks every result.
// ----------------------------------------------------------------------------
// Each accepted input beat is folded into a model of the window sum, count,
// previous mean and drop flag. An update beat queues the result it must give.
// Each accepted result beat is checked field by field against the oldest
// queued result. The fault count and the number of results still owed go to
// the bench top.
module window_average_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] sample, [15:12] zero
  input  logic [0:0]  in_tuser,     // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,    // [11:0] average, [27:12] window_count, [31:28] zero
  input  logic [1:0]  out_tuser,    // [0] window_empty, [1] samples_dropped
  output int unsigned fault_count,
  output int unsigned results_owed
);

  typedef struct packed {
    logic [pswa_pkg::MEAN_W-1:0] average;
    logic                        window_empty;
    logic                        samples_dropped;
    logic [pswa_pkg::CNT_W-1:0]  window_count;
  } window_result_t;

  // Model of the averager's window
  logic [pswa_pkg::SUM_W-1:0]  win_sum;
  logic [pswa_pkg::CNT_W-1:0]  win_tally;
  logic [pswa_pkg::MEAN_W-1:0] prev_mean;
  logic                        drop_seen;

  window_result_t    means_due[$];
  int unsigned       faults;

  initial begin
    faults = 0;
  end

  // Print one line per mismatch and count it
  task automatic note_fault(input string what, input int unsigned got,
                            input int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    faults++;
  endtask

  // Fold one accepted input beat into the window model
  task automatic fold_in_beat(input logic op, input logic [pswa_pkg::SAMPLE_W-1:0] smp);
    window_result_t             res;
    logic [pswa_pkg::SUM_W-1:0] quot;
    if (op == pswa_pkg::OP_SAMPLE) begin
      // Count the sample, or drop it once the window is full
      if (win_tally < pswa_pkg::MAX_SAMPLES) begin
        win_sum   = win_sum + pswa_pkg::SUM_W'(smp);
        win_tally = win_tally + pswa_pkg::CNT_W'(1);
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      res.samples_dropped = drop_seen;
      res.window_count    = win_tally;
      if (win_tally == '0) begin
        // Empty window: repeat the previous mean
        res.average      = prev_mean;
        res.window_empty = 1'b1;
      end else begin
        quot             = win_sum / pswa_pkg::SUM_W'(win_tally);
        prev_mean        = quot[pswa_pkg::MEAN_W-1:0];
        res.average      = prev_mean;
        res.window_empty = 1'b0;
      end
      means_due.push_back(res);
      win_sum   = '0;
      win_tally = '0;
      drop_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (!rst_n) begin
      win_sum   = '0;
      win_tally = '0;
      prev_mean = '0;
      drop_seen = 1'b0;
      means_due.delete();
    end else begin
      // Check the result beat before folding in a beat of the same edge
      if (out_tvalid && out_tready) begin
        got.average         = out_tdata[pswa_pkg::MEAN_W-1:0];
        got.window_count    = out_tdata[pswa_pkg::MEAN_W +: pswa_pkg::CNT_W];
        got.window_empty    = out_tuser[0];
        got.samples_dropped = out_tuser[1];
        if (means_due.size() == 0) begin
          note_fault("result beat with no result owed, average", 32'(got.average), 0);
        end else begin
          want = means_due.pop_front();
          if (got.average != want.average)
            note_fault("average", 32'(got.average), 32'(want.average));
          if (got.window_empty != want.window_empty)
            note_fault("window_empty", 32'(got.window_empty), 32'(want.window_empty));
          if (got.samples_dropped != want.samples_dropped)
            note_fault("samples_dropped", 32'(got.samples_dropped),
                       32'(want.samples_dropped));
          if (got.window_count != want.window_count)
            note_fault("window_count", 32'(got.window_count), 32'(want.window_count));
        end
      end
      if (in_tvalid && in_tready)
        fold_in_beat(in_tuser[0], in_tdata[pswa_pkg::SAMPLE_W-1:0]);
    end
    fault_count  <= faults;
    results_owed <= means_due.size();
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the pressure sample window averager.
// ----------------------------------------------------------------------------
// Sends a directed set of windows (empty windows, extreme and truncated means),
// then random windows of mixed length. Both streams idle at random, save for a
// stretch with no idles; the sender waits for all results to drain mid-run and
// at the end. The checker beside the block does the prediction and comparison.
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned TAIL_CYCLES  = 60;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  int unsigned fault_count;
  int unsigned results_owed;
  int unsigned idle_run = 0;
  logic        calm     = 1'b0;

  pressure_sample_window_average_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  window_average_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fault_count  (fault_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (calm)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50)
      return 0;
    else if (roll < 88)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pswa_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return '0;
    else if (roll == 1)
      return '1;
    else if (roll == 2)
      return pswa_pkg::SAMPLE_W'($urandom_range(0, 15));
    return pswa_pkg::SAMPLE_W'($urandom);
  endfunction

  // Result side: runs of ready broken by stalls
  initial begin : sink
    int unsigned run_len;
    int unsigned stall_len;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      stall_len = gap_len();
      if (stall_len != 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Offer one beat, hold it until taken, then idle a while
  task automatic send_beat(input logic op, input logic [pswa_pkg::SAMPLE_W-1:0] smp);
    int unsigned idle;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, smp};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    idle = gap_len();
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Stop sending until every owed result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned win_len;
    int unsigned roll;
    logic        drained;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows: empty after reset, extremes, truncation, repeats
    send_beat(pswa_pkg::OP_UPDATE, 12'hFFF);
    send_beat(pswa_pkg::OP_SAMPLE, 12'h000);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_SAMPLE, 12'hFFF);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_SAMPLE, 12'hFFF);
    send_beat(pswa_pkg::OP_SAMPLE, 12'hFFE);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_SAMPLE, 12'h001);
    send_beat(pswa_pkg::OP_SAMPLE, 12'h002);
    send_beat(pswa_pkg::OP_UPDATE, 12'hFFF);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_SAMPLE, 12'hAAA);
    send_beat(pswa_pkg::OP_SAMPLE, 12'h555);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);

    // Back-to-back updates around a single mid-scale sample
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);
    send_beat(pswa_pkg::OP_SAMPLE, 12'h7FF);
    send_beat(pswa_pkg::OP_UPDATE, 12'h000);

    // Random windows of mixed length, with a stretch free of idles and one drain
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (!drained && sent >= 900) begin
        drain_results();
        drained = 1'b1;
      end
      calm = (sent >= 400 && sent < 700);
      roll = $urandom_range(0, 99);
      if (roll < 12)
        win_len = 0;
      else if (roll < 82)
        win_len = $urandom_range(1, 12);
      else if (roll < 97)
        win_len = $urandom_range(13, 60);
      else
        win_len = $urandom_range(100, 250);
      repeat (win_len) send_beat(pswa_pkg::OP_SAMPLE, pick_sample());
      send_beat(pswa_pkg::OP_UPDATE, pswa_pkg::SAMPLE_W'($urandom));
      sent += win_len + 1;
    end

    // Let the last results out, then give the block time to settle
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
